// ===== design/brdc_pkg.sv =====
`default_nettype none
package brdc_pkg;

    // Number of banks searched per chunk. Banks past the limit registers have limit zero.
    localparam int NUM_BANKS  = 3;
    localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int LIMIT_REGS = 3;

    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 27;
    localparam int STATUS_W = 3;
    localparam int REGVAL_W = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 192;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ADDR_W-1:0] BUS_BASE     = 32'hB400_0000;
    localparam logic [ADDR_W-1:0] SIZE_REG_OFS = 32'h0002_0000;
    localparam logic [ADDR_W-1:0] WINDOW_OFS   = 32'h0010_0000;
    localparam logic [ADDR_W-1:0] RD_REG_OFS   = 32'h0006_0000;
    localparam logic [ADDR_W-1:0] WR_REG_OFS   = 32'h0007_0000;
    localparam logic [ADDR_W-1:0] LOW_MASK     = 32'h0000_07FC;
    localparam logic [COUNT_W-1:0] MIN_COUNT   = 27'd3;

    localparam logic [ADDR_W-1:0] BANK0_LIMIT_RST = 32'h0200_0000;
    localparam logic [ADDR_W-1:0] BANK1_LIMIT_RST = 32'h0400_0000;
    localparam logic [ADDR_W-1:0] BANK2_LIMIT_RST = 32'h0400_0000;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_CHUNK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOTHING     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK0   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK1   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK2   = 2'd3;

endpackage
`default_nettype wire

// ===== design/banked_ram_dma_chunker.sv =====
// Banked RAM DMA chunker.
// Slave stream: one request per transfer; tdata holds request_addr, host_addr and
// byte_count, tuser holds is_write. Master stream: one result per transfer; tuser
// is the status, tlast marks the final result of a request, tdata holds the chunk.
// Configuration channel: index 0 is running, 1 to 3 are the bank limits; writes
// are always accepted and take effect at once.
// A refused request (not running, missing host address, misaligned, count below 3)
// goes to the status state, which loads its single status result. Otherwise one
// shared 33-bit adder is stepped through bank search (one bank per cycle), length
// clamp, offset and host-address update. The first chunk follows search, clamp and
// emit; each further chunk follows host-address update, search, clamp and emit. An
// address past every limit gives its status result once the last bank is passed.
// A request gives at most four results: up to one chunk per bank and a status.
// The request port is ready only while no request is in progress. A finished
// result sits in the output register; the next request is accepted while it waits.
// A stalled receiver holds the sequencer at the point where it produces a result.
// Reset (synchronous, active low) empties the output, sets running and restores
// the default bank limits.
`default_nettype none
module banked_ram_dma_chunker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [31:0] request_addr, [63:32] host_addr, [90:64] byte_count, [95:91] zero
    input  wire logic [brdc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [0] is_write
    input  wire logic                                i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [1:0] bank, [28:2] chunk_bytes, [60:29] chunk_host_addr, [92:61] size_reg_addr,
    // [108:93] size_reg_value, [140:109] addr_reg_addr, [156:141] addr_reg_value,
    // [188:157] data_window_addr, [191:189] zero
    output logic [brdc_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    // [2:0] status
    output logic [brdc_pkg::STATUS_W-1:0]            o_m_axis_tuser,
    output logic                                     o_m_axis_tlast,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [brdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [brdc_pkg::ADDR_W-1:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CLAMP,
        S_EMIT,
        S_ADVANCE,
        S_STATUS
    } t_state;

    localparam int AW = brdc_pkg::ADDR_W;
    localparam int CW = brdc_pkg::COUNT_W;
    localparam int BW = brdc_pkg::BANK_W;
    localparam logic [BW-1:0] LAST_BANK = BW'(brdc_pkg::NUM_BANKS - 1);

    t_state                       r_state;
    logic                         r_running;
    logic [AW-1:0]                r_limit [brdc_pkg::LIMIT_REGS];
    logic [AW-1:0]                r_cur;
    logic [AW-1:0]                r_host;
    logic [AW-1:0]                r_room;
    logic [AW-1:0]                r_prev;
    logic [CW-1:0]                r_rem;
    logic [CW-1:0]                r_size;
    logic                         r_wr;
    logic [BW-1:0]                r_bank;
    logic [brdc_pkg::STATUS_W-1:0] r_status;

    logic                         r_m_valid;
    logic [brdc_pkg::OUT_DATA_W-1:0] r_m_data;
    logic [brdc_pkg::STATUS_W-1:0] r_m_user;
    logic                         r_m_last;

    // Input fields.
    logic [AW-1:0] in_addr;
    logic [AW-1:0] in_host;
    logic [CW-1:0] in_count;
    logic          s_accept;
    logic          out_free;
    logic          out_load;

    assign in_addr  = i_s_axis_tdata[31:0];
    assign in_host  = i_s_axis_tdata[63:32];
    assign in_count = i_s_axis_tdata[90:64];
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;
    assign out_load = ((r_state == S_EMIT) || (r_state == S_STATUS)) && out_free;

    // Limit of the bank under test; banks past the limit registers read as zero.
    logic [BW+1:0] bank_ext;
    logic [AW-1:0] lim_cur;
    assign bank_ext = {2'b00, r_bank};
    always_comb begin
        if (bank_ext < (BW+2)'(brdc_pkg::LIMIT_REGS)) begin
            lim_cur = r_limit[bank_ext[1:0]];
        end else begin
            lim_cur = '0;
        end
    end

    // Shared 33-bit add/subtract unit. For a subtract, bit 32 is set when a >= b.
    logic [AW-1:0] u_a;
    logic [AW-1:0] u_b;
    logic          u_sub;
    logic [AW:0]   u_res;
    always_comb begin
        unique case (r_state)
            S_SEARCH: begin
                u_a = lim_cur;
                u_b = r_cur;
                u_sub = 1'b1;
            end
            S_CLAMP: begin
                u_a = {{(AW-CW){1'b0}}, r_rem};
                u_b = r_room;
                u_sub = 1'b1;
            end
            S_EMIT: begin
                u_a = r_cur;
                u_b = r_prev;
                u_sub = 1'b1;
            end
            S_ADVANCE: begin
                u_a = r_host;
                u_b = {{(AW-CW){1'b0}}, r_size};
                u_sub = 1'b0;
            end
            default: begin
                u_a = '0;
                u_b = '0;
                u_sub = 1'b0;
            end
        endcase
    end
    assign u_res = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + {{AW{1'b0}}, u_sub};

    logic found;
    assign found = u_res[AW] && (u_res[AW-1:0] != '0);

    // Request checks, in priority order.
    logic [brdc_pkg::STATUS_W-1:0] n_check;
    always_comb begin
        priority if (!r_running) begin
            n_check = brdc_pkg::ST_NOT_RUNNING;
        end else if (in_host == '0) begin
            n_check = brdc_pkg::ST_BAD_ARG;
        end else if ((in_addr[1:0] != 2'b00) || (in_host[1:0] != 2'b00)) begin
            n_check = brdc_pkg::ST_MISALIGNED;
        end else if (in_count < brdc_pkg::MIN_COUNT) begin
            n_check = brdc_pkg::ST_NOTHING;
        end else begin
            n_check = brdc_pkg::ST_CHUNK;
        end
    end

    // Chunk result word; the offset comes from the shared unit in S_EMIT.
    logic [AW-1:0] offset;
    logic [AW-1:0] bank_base;
    logic [brdc_pkg::OUT_DATA_W-1:0] n_chunk;
    assign offset    = u_res[AW-1:0];
    assign bank_base = brdc_pkg::BUS_BASE + (AW'(r_bank) << 21);
    always_comb begin
        n_chunk          = '0;
        n_chunk[1:0]     = 2'(r_bank);
        n_chunk[28:2]    = r_size;
        n_chunk[60:29]   = r_host;
        n_chunk[92:61]   = bank_base + brdc_pkg::SIZE_REG_OFS
                         + ({{(AW-CW){1'b0}}, r_size} & brdc_pkg::LOW_MASK);
        n_chunk[108:93]  = r_size[26:11];
        n_chunk[140:109] = bank_base + (offset & brdc_pkg::LOW_MASK)
                         + (r_wr ? brdc_pkg::WR_REG_OFS : brdc_pkg::RD_REG_OFS);
        n_chunk[156:141] = offset[26:11];
        n_chunk[188:157] = bank_base + brdc_pkg::WINDOW_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_running  <= 1'b1;
            r_limit[0] <= brdc_pkg::BANK0_LIMIT_RST;
            r_limit[1] <= brdc_pkg::BANK1_LIMIT_RST;
            r_limit[2] <= brdc_pkg::BANK2_LIMIT_RST;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    brdc_pkg::CFG_RUNNING: r_running  <= i_cfg_data[0];
                    brdc_pkg::CFG_BANK0:   r_limit[0] <= i_cfg_data;
                    brdc_pkg::CFG_BANK1:   r_limit[1] <= i_cfg_data;
                    brdc_pkg::CFG_BANK2:   r_limit[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_cur    <= in_addr;
                        r_host   <= in_host;
                        r_rem    <= in_count;
                        r_wr     <= i_s_axis_tuser;
                        r_bank   <= '0;
                        r_prev   <= '0;
                        r_status <= n_check;
                        if (n_check == brdc_pkg::ST_CHUNK) begin
                            r_state <= S_SEARCH;
                        end else begin
                            r_state <= S_STATUS;
                        end
                    end
                end
                S_SEARCH: begin
                    r_room <= u_res[AW-1:0];
                    if (found) begin
                        r_state <= S_CLAMP;
                    end else if (r_bank == LAST_BANK) begin
                        r_status <= brdc_pkg::ST_OUT_OF_RANGE;
                        r_state  <= S_STATUS;
                    end else begin
                        r_prev <= lim_cur;
                        r_bank <= r_bank + 1'b1;
                    end
                end
                S_CLAMP: begin
                    // The chunk stops at the bank limit when the request reaches it.
                    if (u_res[AW]) begin
                        r_size <= r_room[CW-1:0];
                        r_rem  <= u_res[CW-1:0];
                    end else begin
                        r_size <= r_rem;
                        r_rem  <= '0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_m_data  <= n_chunk;
                        r_m_user  <= brdc_pkg::ST_CHUNK;
                        r_m_last  <= (r_rem == '0);
                        if (r_rem == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ADVANCE;
                        end
                    end
                end
                S_ADVANCE: begin
                    // The chunk ended on this bank's limit; lower banks cannot match.
                    r_host <= u_res[AW-1:0];
                    r_cur  <= lim_cur;
                    r_prev <= lim_cur;
                    if (r_bank == LAST_BANK) begin
                        r_status <= brdc_pkg::ST_OUT_OF_RANGE;
                        r_state  <= S_STATUS;
                    end else begin
                        r_bank  <= r_bank + 1'b1;
                        r_state <= S_SEARCH;
                    end
                end
                S_STATUS: begin
                    if (out_free) begin
                        r_m_data  <= '0;
                        r_m_user  <= r_status;
                        r_m_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;
    assign o_m_axis_tlast  = r_m_last;

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_user != brdc_pkg::ST_CHUNK)) |-> r_m_last)
        else $error("status result without last");

    a_status_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_user != brdc_pkg::ST_CHUNK)) |-> (r_m_data == '0))
        else $error("status result carries chunk data");

    a_chunk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_user == brdc_pkg::ST_CHUNK)) |-> (r_m_data[28:2] != '0))
        else $error("empty chunk emitted");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("request port ready while a request is in progress");

endmodule
`default_nettype wire

// ===== tb/sv/banked_ram_dma_chunker_tb.sv =====
module banked_ram_dma_chunker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brdc_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 200;
    localparam logic [COUNT_W-1:0] MAX_COUNT = 27'd67108864;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BANK_W-1:0]   bank;
        logic [COUNT_W-1:0]  chunk_bytes;
        logic [ADDR_W-1:0]   chunk_host_addr;
        logic [ADDR_W-1:0]   size_reg_addr;
        logic [REGVAL_W-1:0] size_reg_value;
        logic [ADDR_W-1:0]   addr_reg_addr;
        logic [REGVAL_W-1:0] addr_reg_value;
        logic [ADDR_W-1:0]   data_window_addr;
        logic                last;
    } t_chunk_res;

    class chunk_ledger;
        logic              running;
        logic [ADDR_W-1:0] limit [8];
        t_chunk_res        awaited [$];
        int errors, requests, results, chunks, refusals;

        function new();
            foreach (limit[i]) limit[i] = '0;
            running  = 1'b1;
            limit[0] = BANK0_LIMIT_RST;
            limit[1] = BANK1_LIMIT_RST;
            limit[2] = BANK2_LIMIT_RST;
            errors   = 0;
            requests = 0;
            results  = 0;
            chunks   = 0;
            refusals = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
            case (idx)
                CFG_RUNNING: running  = val[0];
                CFG_BANK0:   limit[0] = val;
                CFG_BANK1:   limit[1] = val;
                CFG_BANK2:   limit[2] = val;
                default: ;
            endcase
        endfunction

        function void push_status(logic [STATUS_W-1:0] st);
            t_chunk_res r;
            r = '{default: '0};
            r.status = st;
            r.last   = 1'b1;
            awaited.push_back(r);
            if (st != ST_CHUNK) refusals++;
        endfunction

        // Splits one accepted request into its expected chunk results.
        function void split_request(logic [ADDR_W-1:0] ram_addr, logic [ADDR_W-1:0] host,
                                    logic [COUNT_W-1:0] count, logic wr);
            t_chunk_res        r;
            logic [ADDR_W-1:0] addr_now, host_now, len, ofs, bank_base;
            logic [COUNT_W-1:0] left;
            int sel, n, i;
            bit done;
            requests++;
            if (!running) begin
                push_status(ST_NOT_RUNNING);
                return;
            end
            if (host == '0) begin
                push_status(ST_BAD_ARG);
                return;
            end
            if (ram_addr[1:0] != 2'b00 || host[1:0] != 2'b00) begin
                push_status(ST_MISALIGNED);
                return;
            end
            if (count < MIN_COUNT) begin
                push_status(ST_NOTHING);
                return;
            end
            addr_now = ram_addr;
            host_now = host;
            left     = count;
            n        = 0;
            done     = 1'b0;
            while (!done && left != '0 && n < 4) begin
                sel = -1;
                for (i = 0; i < NUM_BANKS && i < 8; i++)
                    if (sel < 0 && addr_now < limit[i]) sel = i;
                if (sel < 0) begin
                    push_status(ST_OUT_OF_RANGE);
                    done = 1'b1;
                end else begin
                    len = ADDR_W'(left);
                    // The end of the chunk is compared with the limit one bit wider,
                    // so a request near the top of memory does not wrap.
                    if ({1'b0, addr_now} + {1'b0, len} >= {1'b0, limit[sel]})
                        len = limit[sel] - addr_now;
                    ofs = addr_now;
                    if (sel > 0) ofs = ofs - limit[sel-1];
                    bank_base = BUS_BASE + (ADDR_W'(sel) << 21);
                    r.status           = ST_CHUNK;
                    r.bank             = BANK_W'(sel);
                    r.chunk_bytes      = len[COUNT_W-1:0];
                    r.chunk_host_addr  = host_now;
                    r.size_reg_addr    = bank_base + SIZE_REG_OFS + (len & LOW_MASK);
                    r.size_reg_value   = REGVAL_W'(len >> 11);
                    r.addr_reg_addr    = bank_base + (ofs & LOW_MASK)
                                         + (wr ? WR_REG_OFS : RD_REG_OFS);
                    r.addr_reg_value   = REGVAL_W'(ofs >> 11);
                    r.data_window_addr = bank_base + WINDOW_OFS;
                    left     = left - len[COUNT_W-1:0];
                    addr_now = addr_now + len;
                    host_now = host_now + len;
                    r.last   = (left == '0);
                    awaited.push_back(r);
                    chunks++;
                end
                n++;
            end
        endfunction

        function void check_field(string field, logic [ADDR_W-1:0] want,
                                  logic [ADDR_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_chunk(t_chunk_res got);
            t_chunk_res want;
            results++;
            if (awaited.size() == 0) begin
                $error("unexpected result transfer with status %0d", got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            check_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
            check_field("bank", ADDR_W'(want.bank), ADDR_W'(got.bank));
            check_field("chunk_bytes", ADDR_W'(want.chunk_bytes), ADDR_W'(got.chunk_bytes));
            check_field("chunk_host_addr", want.chunk_host_addr, got.chunk_host_addr);
            check_field("size_reg_addr", want.size_reg_addr, got.size_reg_addr);
            check_field("size_reg_value", ADDR_W'(want.size_reg_value),
                        ADDR_W'(got.size_reg_value));
            check_field("addr_reg_addr", want.addr_reg_addr, got.addr_reg_addr);
            check_field("addr_reg_value", ADDR_W'(want.addr_reg_value),
                        ADDR_W'(got.addr_reg_value));
            check_field("data_window_addr", want.data_window_addr, got.data_window_addr);
            check_field("last", ADDR_W'(want.last), ADDR_W'(got.last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]   o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [ADDR_W-1:0]     i_cfg_data;

    chunk_ledger ledger = new();
    t_chunk_res  seen;
    bit          steady = 1'b0;
    int          hold_off_req = 0;
    int          idle_cycles = 0;
    int          settings = 1;

    banked_ram_dma_chunker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.status           = o_m_axis_tuser;
            seen.bank             = o_m_axis_tdata[1:0];
            seen.chunk_bytes      = o_m_axis_tdata[28:2];
            seen.chunk_host_addr  = o_m_axis_tdata[60:29];
            seen.size_reg_addr    = o_m_axis_tdata[92:61];
            seen.size_reg_value   = o_m_axis_tdata[108:93];
            seen.addr_reg_addr    = o_m_axis_tdata[140:109];
            seen.addr_reg_value   = o_m_axis_tdata[156:141];
            seen.data_window_addr = o_m_axis_tdata[188:157];
            seen.last             = o_m_axis_tlast;
            ledger.check_chunk(seen);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink: random stalls, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req > 0) begin
                hold_left = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic offer_request(input logic [ADDR_W-1:0] ram_addr,
                                 input logic [ADDR_W-1:0] host,
                                 input logic [COUNT_W-1:0] count, input logic wr);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 21) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, count, host, ram_addr};
        i_s_axis_tuser  <= wr;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ledger.split_request(ram_addr, host, count, wr);
    endtask

    // Stops offering requests until every expected result has been seen.
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (ledger.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.set_reg(idx, val);
        settings++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_limits(input logic [ADDR_W-1:0] l0, input logic [ADDR_W-1:0] l1,
                                input logic [ADDR_W-1:0] l2);
        write_reg(CFG_BANK0, l0);
        write_reg(CFG_BANK1, l1);
        write_reg(CFG_BANK2, l2);
    endtask

    // Mostly well-formed requests, half aimed at bank boundaries, some refused ones.
    task automatic random_request();
        logic [ADDR_W-1:0]  a, h, top;
        logic [COUNT_W-1:0] c;
        logic               w;
        int pick, j;
        w = 1'($urandom_range(1, 0));
        h = $urandom & 32'hFFFF_FFFC;
        if (h == '0) h = 32'h4;
        pick = $urandom_range(99);
        if (pick < 50) begin
            j = $urandom_range(2, 0);
            a = (ledger.limit[j] - ($urandom_range(1024, 0) << 2)) & 32'hFFFF_FFFC;
        end else if (pick < 75) begin
            top = ledger.limit[0];
            if (ledger.limit[1] > top) top = ledger.limit[1];
            if (ledger.limit[2] > top) top = ledger.limit[2];
            a = (top == '0) ? '0 : (($urandom % top) & 32'hFFFF_FFFC);
        end else begin
            a = $urandom & 32'hFFFF_FFFC;
        end
        pick = $urandom_range(99);
        if (pick < 55) c = COUNT_W'($urandom_range(32'h3000, 3));
        else if (pick < 95) c = COUNT_W'($urandom_range(MAX_COUNT, 3));
        else c = MAX_COUNT;
        pick = $urandom_range(99);
        if (pick < 3) h = '0;
        else if (pick < 6) a = a | ADDR_W'($urandom_range(3, 1));
        else if (pick < 9) h = h | ADDR_W'($urandom_range(3, 1));
        else if (pick < 12) c = COUNT_W'($urandom_range(2, 0));
        offer_request(a, h, c, w);
    endtask

    task automatic random_phase(input int n_items, input int hold_at);
        for (int k = 0; k < n_items; k++) begin
            if (k == hold_at) hold_off_req = HOLD_CYCLES;
            random_request();
        end
        settle();
    endtask

    initial begin
        logic [ADDR_W-1:0] x, y, z, t;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_RUNNING;
        i_cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default bank layout: short counts, refusals in check order, clamping.
        offer_request(32'h0, 32'h4, 27'd0, 1'b0);
        offer_request(32'h10, 32'h100, 27'd2, 1'b1);
        offer_request(32'h0, 32'h100, 27'd3, 1'b0);
        offer_request(32'h100, 32'h0, 27'h40, 1'b0);
        offer_request(32'h102, 32'h100, 27'h40, 1'b0);
        offer_request(32'h100, 32'hFFFF_FFFE, 27'h40, 1'b1);
        offer_request(32'h101, 32'h0, 27'h40, 1'b0);
        offer_request(32'h01FF_FFFC, 32'h1000, MAX_COUNT, 1'b1);
        offer_request(32'h0400_0000, 32'h1000, 27'h800, 1'b0);
        offer_request(32'hFFFF_FFFC, 32'hFFFF_FFFC, MAX_COUNT, 1'b1);
        offer_request(32'h0, 32'h2000, 27'h200_0000, 1'b0);
        offer_request(32'h0200_07FC, 32'h3000, 27'h1804, 1'b1);
        offer_request(32'h0, 32'h10, MAX_COUNT, 1'b0);
        offer_request(32'h01FF_FFF0, 32'hFFFF_FFF8, 27'h20, 1'b1);
        offer_request(32'h7FC, 32'h7FFF_FFFC, 27'h7FF, 1'b0);
        settle();

        write_reg(CFG_RUNNING, 32'h0);
        offer_request(32'h100, 32'h0, 27'd0, 1'b0);
        offer_request(32'h3, 32'h5, 27'h10, 1'b1);
        settle();
        write_reg(CFG_RUNNING, 32'h1);

        apply_limits(32'h0, 32'h0, 32'h0);
        offer_request(32'h0, 32'h4, 27'h10, 1'b0);
        settle();
        // The clamp at the top of the address space must not wrap.
        apply_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(32'hFFFF_FFF8, 32'h4, 27'h100, 1'b1);
        offer_request(32'h8000_0000, 32'h8000_0000, MAX_COUNT, 1'b0);
        settle();
        // Bank one's limit sits below bank zero's, so it is skipped.
        apply_limits(32'h8000, 32'h4000, 32'h1_0000);
        offer_request(32'h2000, 32'h40, 27'h2_0000, 1'b1);
        settle();

        apply_limits(BANK0_LIMIT_RST, BANK1_LIMIT_RST, BANK2_LIMIT_RST);
        random_phase(30, 10);

        x = ADDR_W'($urandom_range(16, 1)) << 10;
        y = x + (ADDR_W'($urandom_range(16, 1)) << 10);
        z = y + (ADDR_W'($urandom_range(16, 1)) << 10);
        apply_limits(x, y, z);
        steady = 1'b1;
        random_phase(30, -1);
        steady = 1'b0;

        x = $urandom;
        y = $urandom;
        z = $urandom;
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        apply_limits(x, y, z);
        random_phase(25, -1);

        apply_limits($urandom_range(32'h2_0000, 0), $urandom_range(32'h2_0000, 0),
                     $urandom_range(32'h2_0000, 0));
        random_phase(20, -1);

        write_reg(CFG_RUNNING, 32'h0);
        random_phase(5, -1);
        write_reg(CFG_RUNNING, 32'h1);
        x = $urandom_range(32'h7FFF_FFFF, 0);
        apply_limits(x, x + $urandom_range(32'h7FFF_FFFF, 0), 32'hFFFF_FFFF);
        random_phase(30, -1);

        repeat (30) @(posedge i_clk);
        $display("Checked %0d requests giving %0d results (%0d chunks, %0d status-only).",
                 ledger.requests, ledger.results, ledger.chunks, ledger.refusals);
        $display("Covered %0d register settings, random stalls and a %0d-cycle sink hold-off.",
                 settings, HOLD_CYCLES);
        if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (ledger.awaited.size() != 0)
                $error("%0d expected results never arrived", ledger.awaited.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/brdc_pkg.sv
design/banked_ram_dma_chunker.sv
tb/sv/banked_ram_dma_chunker_tb.sv
